FILE: rtl/vertex_weld_dedup_defines.svh
// assertion helpers shared by the weld block
`ifndef VERTEX_WELD_DEDUP_DEFINES_SVH
`define VERTEX_WELD_DEDUP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define VWD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define VWD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/vwd_pkg.sv
package vwd_pkg;

    localparam int POS_W     = 16;
    localparam int OUT_NRM_W = 24;
    localparam int DIST_W    = 36;
    localparam int CFG_AW    = 4;
    localparam int CFG_DW    = 64;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // register select bit of paddr: 0 tolerance_mode, 1 weld_dist_sq
    localparam logic REG_MODE = 1'b0;
    localparam logic REG_DIST = 1'b1;

    localparam logic [DIST_W-1:0] DIST_RESET = 36'd369;

    typedef struct packed {
        logic valid;
        logic hit;
    } match_res_t;

endpackage

FILE: rtl/vwd_cell.sv
module vwd_cell #(
    parameter int W = 120
) (
    input  logic         clk,
    input  logic         shift_en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] data_reg;

    // one entry of the ring, moves one place toward the head per shift
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            data_reg <= din;
        end
    end

    assign dout = data_reg;

endmodule

FILE: rtl/vwd_match.sv
module vwd_match #(
    parameter int TW = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             mode,
    input  logic [vwd_pkg::DIST_W-1:0]       thr,
    input  logic signed [vwd_pkg::POS_W-1:0] a_x,
    input  logic signed [vwd_pkg::POS_W-1:0] a_y,
    input  logic signed [vwd_pkg::POS_W-1:0] a_z,
    input  logic signed [vwd_pkg::POS_W-1:0] b_x,
    input  logic signed [vwd_pkg::POS_W-1:0] b_y,
    input  logic signed [vwd_pkg::POS_W-1:0] b_z,
    input  logic [TW-1:0]                    tag,
    output vwd_pkg::match_res_t              res,
    output logic [TW-1:0]                    res_tag
);

    localparam int DW = vwd_pkg::POS_W + 1;
    localparam int SW = 2 * DW;

    logic signed [DW-1:0] dx_reg, dy_reg, dz_reg;
    logic [SW-1:0]        sx_reg, sy_reg, sz_reg;
    logic                 v1_reg, v2_reg, z2_reg;
    logic [TW-1:0]        t1_reg, t2_reg;
    logic [vwd_pkg::DIST_W-1:0] dist_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // stage 1 differences, stage 2 squares
    always_ff @(posedge clk)
    begin
        dx_reg <= DW'(a_x) - DW'(b_x);
        dy_reg <= DW'(a_y) - DW'(b_y);
        dz_reg <= DW'(a_z) - DW'(b_z);
        t1_reg <= tag;
        sx_reg <= SW'(dx_reg * dx_reg);
        sy_reg <= SW'(dy_reg * dy_reg);
        sz_reg <= SW'(dz_reg * dz_reg);
        z2_reg <= (dx_reg == '0) && (dy_reg == '0) && (dz_reg == '0);
        t2_reg <= t1_reg;
    end

    assign dist_sum  = vwd_pkg::DIST_W'(sx_reg) + vwd_pkg::DIST_W'(sy_reg)
                       + vwd_pkg::DIST_W'(sz_reg);
    assign res.valid = v2_reg;
    assign res.hit   = mode ? (dist_sum < thr) : z2_reg;
    assign res_tag   = t2_reg;

endmodule

FILE: rtl/vertex_weld_dedup.sv
// Vertex weld table. Entries live in a ring of DEPTH cells that rotates one
// place per cycle during search, update and read turns, past a single
// comparator at the head. An insert makes one full search turn, waits in the
// drain state for the comparator pipeline, then, on a hit or when room
// remains, makes one update turn in which the hit entry's normals are summed
// or the new entry is written; on a full table it ends after the drain. A
// read takes one turn; clear and the unused command finish without a turn.
// busy is high while an insert or read is in work; every transaction gives
// exactly one result, shown for one cycle with done high. The receiver cannot
// stall, so results must be taken the cycle they appear. Stored entries
// beyond the count are stale and never reported.
`include "vertex_weld_dedup_defines.svh"

module vertex_weld_dedup #(
    parameter int DEPTH            = 256,
    parameter int NORMAL_SUM_WIDTH = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // command side
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         cmd,
    input  logic signed [15:0]                 pos_x,
    input  logic signed [15:0]                 pos_y,
    input  logic signed [15:0]                 pos_z,
    input  logic signed [15:0]                 nrm_x,
    input  logic signed [15:0]                 nrm_y,
    input  logic signed [15:0]                 nrm_z,
    input  logic [7:0]                         read_index,
    // result side
    output logic                               done,
    output logic [7:0]                         vertex_index,
    output logic                               is_new,
    output logic                               table_full,
    output logic signed [15:0]                 out_pos_x,
    output logic signed [15:0]                 out_pos_y,
    output logic signed [15:0]                 out_pos_z,
    output logic signed [23:0]                 out_nrm_x,
    output logic signed [23:0]                 out_nrm_y,
    output logic signed [23:0]                 out_nrm_z,
    output logic [8:0]                         unique_count,
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [vwd_pkg::CFG_AW-1:0]         paddr,
    input  logic [vwd_pkg::CFG_DW-1:0]         pwdata,
    output logic [vwd_pkg::CFG_DW-1:0]         prdata,
    output logic                               pready
);

    localparam int NSW = NORMAL_SUM_WIDTH;
    localparam int KW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int PW  = vwd_pkg::POS_W;
    localparam int EW  = 3 * PW + 3 * NSW;
    localparam int XW  = CW + 9;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DRAIN,
        S_UPDATE,
        S_READ
    } state_t;

    state_t state_reg;

    // register file
    logic                        mode_reg;
    logic [vwd_pkg::DIST_W-1:0]  dist_reg;
    logic                        cfg_wr;

    // latched transaction
    logic signed [PW-1:0]  px_reg, py_reg, pz_reg, nx_reg, ny_reg, nz_reg;
    logic [7:0]            ridx_reg;

    // sequencing
    logic [KW-1:0] k_reg;
    logic [KW-1:0] target_reg;
    logic [KW-1:0] hit_idx_reg;
    logic [CW-1:0] count_reg;
    logic          found_reg;
    logic          drain_reg;
    logic          last_k;
    logic          done_next;

    // ring
    logic [EW-1:0] ring [DEPTH];
    logic [EW-1:0] head;
    logic [EW-1:0] head_next;
    logic          shift_en;

    logic signed [PW-1:0]  h_px, h_py, h_pz;
    logic signed [NSW-1:0] h_nx, h_ny, h_nz;

    // comparator
    vwd_pkg::match_res_t m_res;
    logic [KW-1:0]       m_tag;
    logic                m_in_valid;
    logic                hit_now;
    logic                found_eff;
    logic [KW-1:0]       idx_eff;

    logic [XW-1:0] ridx_x, k_x, count_x, target_x;
    logic          read_ok;
    logic          at_read;

    function automatic logic [NSW-1:0] sat_add(input logic [NSW-1:0] a,
                                               input logic [PW-1:0] b);
        logic [NSW:0] s;
        s = {a[NSW-1], a} + {{(NSW + 1 - PW){b[PW-1]}}, b};
        if (s[NSW] != s[NSW-1])
        begin
            return s[NSW] ? {1'b1, {(NSW - 1){1'b0}}} : {1'b0, {(NSW - 1){1'b1}}};
        end
        return s[NSW-1:0];
    endfunction

    function automatic logic [23:0] to_out(input logic [NSW-1:0] v);
        logic signed [32:0] w;
        w = {{(33 - NSW){v[NSW-1]}}, v};
        if (w > 33'sd8388607)
        begin
            return 24'h7fffff;
        end
        if (w < -33'sd8388608)
        begin
            return 24'h800000;
        end
        return w[23:0];
    endfunction

    // register port: reg 0 at byte 0, reg 1 at byte 8
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            dist_reg <= vwd_pkg::DIST_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[3] == vwd_pkg::REG_MODE)
            begin
                mode_reg <= pwdata[0];
            end
            else
            begin
                dist_reg <= pwdata[vwd_pkg::DIST_W-1:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[3] == vwd_pkg::REG_DIST)
        begin
            prdata[vwd_pkg::DIST_W-1:0] = dist_reg;
        end
        else
        begin
            prdata[0] = mode_reg;
        end
    end

    // ring of cells, head at cell 0, turned-around entry re-enters at the tail
    assign shift_en = (state_reg == S_SEARCH) || (state_reg == S_UPDATE)
                      || (state_reg == S_READ);

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_ring
        if (i == DEPTH - 1)
        begin : g_tail
            vwd_cell #(.W(EW)) u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .din      (head_next),
                .dout     (ring[i])
            );
        end
        else
        begin : g_body
            vwd_cell #(.W(EW)) u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .din      (ring[i+1]),
                .dout     (ring[i])
            );
        end
    end

    assign head = ring[0];
    assign h_px = head[EW-1 -: PW];
    assign h_py = head[EW-1-PW -: PW];
    assign h_pz = head[EW-1-2*PW -: PW];
    assign h_nx = head[3*NSW-1 -: NSW];
    assign h_ny = head[2*NSW-1 -: NSW];
    assign h_nz = head[NSW-1:0];

    assign last_k   = (k_reg == KW'(DEPTH - 1));
    assign k_x      = XW'(k_reg);
    assign ridx_x   = XW'(ridx_reg);
    assign count_x  = XW'(count_reg);
    assign target_x = XW'(target_reg);
    assign read_ok  = ridx_x < count_x;
    assign at_read  = read_ok && (k_x == ridx_x);

    // update turn: sum normals into the hit entry, or write the new entry
    always_comb
    begin
        head_next = head;
        if ((state_reg == S_UPDATE) && (k_reg == target_reg))
        begin
            if (found_reg)
            begin
                head_next = {h_px, h_py, h_pz, sat_add(h_nx, nx_reg),
                             sat_add(h_ny, ny_reg), sat_add(h_nz, nz_reg)};
            end
            else
            begin
                head_next = {px_reg, py_reg, pz_reg,
                             {{(NSW - PW){nx_reg[PW-1]}}, nx_reg},
                             {{(NSW - PW){ny_reg[PW-1]}}, ny_reg},
                             {{(NSW - PW){nz_reg[PW-1]}}, nz_reg}};
            end
        end
    end

    // search compares only stored entries
    assign m_in_valid = (state_reg == S_SEARCH) && (CW'(k_reg) < count_reg);

    vwd_match #(.TW(KW)) u_match (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (m_in_valid),
        .mode     (mode_reg),
        .thr      (dist_reg),
        .a_x      (px_reg),
        .a_y      (py_reg),
        .a_z      (pz_reg),
        .b_x      (h_px),
        .b_y      (h_py),
        .b_z      (h_pz),
        .tag      (k_reg),
        .res      (m_res),
        .res_tag  (m_tag)
    );

    // first match in index order wins
    assign hit_now   = m_res.valid && m_res.hit && !found_reg;
    assign found_eff = found_reg || hit_now;
    assign idx_eff   = hit_now ? m_tag : hit_idx_reg;

    assign busy = (state_reg != S_IDLE);

    // result strobe: clear and unused command at once, full miss after the
    // drain, insert update and read at the end of their turn
    assign done_next = ((state_reg == S_IDLE) && start && (cmd != vwd_pkg::CMD_INSERT)
                        && (cmd != vwd_pkg::CMD_READ))
                       || ((state_reg == S_DRAIN) && drain_reg && !found_eff
                           && (count_reg >= CW'(DEPTH)))
                       || (((state_reg == S_UPDATE) || (state_reg == S_READ)) && last_k);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            done         <= 1'b0;
            found_reg    <= 1'b0;
            drain_reg    <= 1'b0;
            k_reg        <= '0;
            target_reg   <= '0;
            hit_idx_reg  <= '0;
            px_reg       <= '0;
            py_reg       <= '0;
            pz_reg       <= '0;
            nx_reg       <= '0;
            ny_reg       <= '0;
            nz_reg       <= '0;
            ridx_reg     <= '0;
            out_pos_x    <= '0;
            out_pos_y    <= '0;
            out_pos_z    <= '0;
            out_nrm_x    <= '0;
            out_nrm_y    <= '0;
            out_nrm_z    <= '0;
            is_new       <= 1'b0;
            table_full   <= 1'b0;
            vertex_index <= '0;
            unique_count <= '0;
        end
        else
        begin
            done <= done_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        px_reg    <= pos_x;
                        py_reg    <= pos_y;
                        pz_reg    <= pos_z;
                        nx_reg    <= nrm_x;
                        ny_reg    <= nrm_y;
                        nz_reg    <= nrm_z;
                        ridx_reg  <= read_index;
                        k_reg     <= '0;
                        found_reg <= 1'b0;
                        drain_reg <= 1'b0;
                        out_pos_x <= '0;
                        out_pos_y <= '0;
                        out_pos_z <= '0;
                        out_nrm_x <= '0;
                        out_nrm_y <= '0;
                        out_nrm_z <= '0;
                        is_new     <= 1'b0;
                        table_full <= 1'b0;
                        vertex_index <= '0;
                        case (cmd)
                            vwd_pkg::CMD_INSERT:
                            begin
                                state_reg <= S_SEARCH;
                            end
                            vwd_pkg::CMD_READ:
                            begin
                                state_reg <= S_READ;
                            end
                            vwd_pkg::CMD_CLEAR:
                            begin
                                count_reg    <= '0;
                                unique_count <= '0;
                            end
                            default:
                            begin
                                unique_count <= count_x[8:0];
                            end
                        endcase
                    end
                end
                S_SEARCH:
                begin
                    found_reg   <= found_eff;
                    hit_idx_reg <= idx_eff;
                    if (last_k)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    found_reg   <= found_eff;
                    hit_idx_reg <= idx_eff;
                    if (drain_reg)
                    begin
                        drain_reg <= 1'b0;
                        if (found_eff)
                        begin
                            target_reg <= idx_eff;
                            state_reg  <= S_UPDATE;
                        end
                        else if (count_reg < CW'(DEPTH))
                        begin
                            target_reg <= count_reg[KW-1:0];
                            state_reg  <= S_UPDATE;
                        end
                        else
                        begin
                            table_full   <= 1'b1;
                            unique_count <= count_x[8:0];
                            state_reg    <= S_IDLE;
                        end
                    end
                    else
                    begin
                        drain_reg <= 1'b1;
                    end
                end
                S_UPDATE:
                begin
                    if (last_k)
                    begin
                        k_reg        <= '0;
                        vertex_index <= target_x[7:0];
                        is_new       <= !found_reg;
                        if (found_reg)
                        begin
                            unique_count <= count_x[8:0];
                        end
                        else
                        begin
                            count_reg    <= count_reg + 1'b1;
                            unique_count <= 9'(count_x + 1'b1);
                        end
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                S_READ:
                begin
                    if (at_read)
                    begin
                        out_pos_x <= h_px;
                        out_pos_y <= h_py;
                        out_pos_z <= h_pz;
                        out_nrm_x <= to_out(h_nx);
                        out_nrm_y <= to_out(h_ny);
                        out_nrm_z <= to_out(h_nz);
                    end
                    if (last_k)
                    begin
                        k_reg        <= '0;
                        vertex_index <= ridx_reg;
                        unique_count <= count_x[8:0];
                        state_reg    <= S_IDLE;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `VWD_ASSERT_NOW(a_count_bound, 1'b1, count_x <= XW'(DEPTH), "entry count above depth")
    `VWD_ASSERT_NOW(a_flags_excl, done, !(is_new && table_full), "new and full together")
    `VWD_ASSERT_NEXT(a_start_busy, start && !busy && (cmd == vwd_pkg::CMD_INSERT), busy,
                     "insert did not start a search")
    `VWD_ASSERT_NOW(a_hit_in_search, m_res.valid,
                    (state_reg == S_SEARCH) || (state_reg == S_DRAIN),
                    "compare result outside search")

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

// one observed or expected weld result
typedef struct {
    logic [7:0]  vertex_index;
    logic        is_new;
    logic        table_full;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic [23:0] nrm_x;
    logic [23:0] nrm_y;
    logic [23:0] nrm_z;
    logic [8:0]  unique_count;
} weld_result_t;

// mirror of the weld table plus the queue of results still owed by the block
class weld_scoreboard;
    localparam int DEPTH   = 256;
    localparam int SUM_MAX = 8388607;
    localparam int SUM_MIN = -8388608;

    logic signed [15:0] store_x[DEPTH];
    logic signed [15:0] store_y[DEPTH];
    logic signed [15:0] store_z[DEPTH];
    int                 sum_x[DEPTH];
    int                 sum_y[DEPTH];
    int                 sum_z[DEPTH];
    int                 entries;
    bit                 tol_mode;
    bit [35:0]          dist_sq;
    weld_result_t       owed_results[$];
    int                 mismatches;
    int                 n_hits, n_new, n_full, n_reads, n_checked;

    function new();
        entries  = 0;
        tol_mode = 1'b0;
        dist_sq  = 36'd369;
    endfunction

    function int clamp_sum(int v);
        if (v > SUM_MAX)
            return SUM_MAX;
        if (v < SUM_MIN)
            return SUM_MIN;
        return v;
    endfunction

    function bit near(int j, logic signed [15:0] px, logic signed [15:0] py,
                      logic signed [15:0] pz);
        longint dx, dy, dz, d2;
        if (!tol_mode)
            return px == store_x[j] && py == store_y[j] && pz == store_z[j];
        dx = longint'(px) - longint'(store_x[j]);
        dy = longint'(py) - longint'(store_y[j]);
        dz = longint'(pz) - longint'(store_z[j]);
        d2 = dx * dx + dy * dy + dz * dz;
        return d2 < longint'(dist_sq);
    endfunction

    // works out the result of one accepted transaction and queues it
    function void note_accepted(logic [1:0] cmd, logic signed [15:0] px,
                                logic signed [15:0] py, logic signed [15:0] pz,
                                logic signed [15:0] nx, logic signed [15:0] ny,
                                logic signed [15:0] nz, logic [7:0] ridx);
        weld_result_t r;
        int           j;
        int           hit_at;
        r = '{default: '0};
        if (cmd == vwd_pkg::CMD_INSERT) begin
            hit_at = -1;
            for (j = 0; j < entries; j++) begin
                if (near(j, px, py, pz)) begin
                    hit_at = j;
                    break;
                end
            end
            if (hit_at >= 0) begin
                sum_x[hit_at] = clamp_sum(sum_x[hit_at] + int'(nx));
                sum_y[hit_at] = clamp_sum(sum_y[hit_at] + int'(ny));
                sum_z[hit_at] = clamp_sum(sum_z[hit_at] + int'(nz));
                r.vertex_index = hit_at[7:0];
                n_hits++;
            end else if (entries < DEPTH) begin
                store_x[entries] = px;
                store_y[entries] = py;
                store_z[entries] = pz;
                sum_x[entries]   = int'(nx);
                sum_y[entries]   = int'(ny);
                sum_z[entries]   = int'(nz);
                r.vertex_index   = entries[7:0];
                r.is_new         = 1'b1;
                entries++;
                n_new++;
            end else begin
                r.table_full = 1'b1;
                n_full++;
            end
        end else if (cmd == vwd_pkg::CMD_READ) begin
            r.vertex_index = ridx;
            n_reads++;
            if (int'(ridx) < entries) begin
                r.pos_x = store_x[ridx];
                r.pos_y = store_y[ridx];
                r.pos_z = store_z[ridx];
                r.nrm_x = sum_x[ridx][23:0];
                r.nrm_y = sum_y[ridx][23:0];
                r.nrm_z = sum_z[ridx][23:0];
            end
        end else if (cmd == vwd_pkg::CMD_CLEAR) begin
            entries = 0;
        end
        r.unique_count = entries[8:0];
        owed_results.push_back(r);
    endfunction

    task report_mismatch(string what);
        $display("tb: mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    task check_result(weld_result_t got);
        weld_result_t exp;
        if (owed_results.size() == 0) begin
            report_mismatch("result with no transaction outstanding");
            return;
        end
        exp = owed_results.pop_front();
        n_checked++;
        if (got.vertex_index !== exp.vertex_index)
            report_mismatch($sformatf("vertex_index %0d, want %0d",
                                      got.vertex_index, exp.vertex_index));
        if (got.is_new !== exp.is_new)
            report_mismatch($sformatf("is_new %b, want %b", got.is_new, exp.is_new));
        if (got.table_full !== exp.table_full)
            report_mismatch($sformatf("table_full %b, want %b",
                                      got.table_full, exp.table_full));
        if (got.pos_x !== exp.pos_x)
            report_mismatch($sformatf("out_pos_x %h, want %h", got.pos_x, exp.pos_x));
        if (got.pos_y !== exp.pos_y)
            report_mismatch($sformatf("out_pos_y %h, want %h", got.pos_y, exp.pos_y));
        if (got.pos_z !== exp.pos_z)
            report_mismatch($sformatf("out_pos_z %h, want %h", got.pos_z, exp.pos_z));
        if (got.nrm_x !== exp.nrm_x)
            report_mismatch($sformatf("out_nrm_x %h, want %h", got.nrm_x, exp.nrm_x));
        if (got.nrm_y !== exp.nrm_y)
            report_mismatch($sformatf("out_nrm_y %h, want %h", got.nrm_y, exp.nrm_y));
        if (got.nrm_z !== exp.nrm_z)
            report_mismatch($sformatf("out_nrm_z %h, want %h", got.nrm_z, exp.nrm_z));
        if (got.unique_count !== exp.unique_count)
            report_mismatch($sformatf("unique_count %0d, want %0d",
                                      got.unique_count, exp.unique_count));
    endtask
endclass

module tb_top;

    // no-op command, the one encoding the package leaves unnamed
    localparam logic [1:0] CMD_NOP = 2'd3;
    // 36-bit register present, so registers sit 8 bytes apart
    localparam logic [vwd_pkg::CFG_AW-1:0] ADDR_MODE = 4'd0;
    localparam logic [vwd_pkg::CFG_AW-1:0] ADDR_DIST = 4'd8;
    localparam logic [vwd_pkg::DIST_W-1:0] DIST_MAX  = {vwd_pkg::DIST_W{1'b1}};

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        cmd = CMD_NOP;
    logic signed [15:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic signed [15:0] nrm_x = '0, nrm_y = '0, nrm_z = '0;
    logic [7:0]        read_index = '0;
    logic              done;
    logic [7:0]        vertex_index;
    logic              is_new, table_full;
    logic signed [15:0] out_pos_x, out_pos_y, out_pos_z;
    logic signed [23:0] out_nrm_x, out_nrm_y, out_nrm_z;
    logic [8:0]        unique_count;
    logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [vwd_pkg::CFG_AW-1:0] paddr = '0;
    logic [vwd_pkg::CFG_DW-1:0] pwdata = '0;
    logic [vwd_pkg::CFG_DW-1:0] prdata;
    logic              pready;

    weld_scoreboard weld_sb = new();

    // vertex pool for the current phase, so inserts land on stored entries
    logic signed [15:0] pool_x[12], pool_y[12], pool_z[12];
    bit                 no_gaps;

    vertex_weld_dedup u_dut (
        .clk(clk), .rst_n(rst_n),
        .start(start), .busy(busy), .cmd(cmd),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .nrm_x(nrm_x), .nrm_y(nrm_y), .nrm_z(nrm_z),
        .read_index(read_index),
        .done(done), .vertex_index(vertex_index), .is_new(is_new),
        .table_full(table_full),
        .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
        .out_nrm_x(out_nrm_x), .out_nrm_y(out_nrm_y), .out_nrm_z(out_nrm_z),
        .unique_count(unique_count),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [15:0] rnd16();
        return 16'($urandom);
    endfunction

    function automatic logic [7:0] rnd8();
        return 8'($urandom);
    endfunction

    // results cannot be stalled: take every done cycle as it comes
    always @(posedge clk)
    begin
        weld_result_t got;
        if (rst_n && done) begin
            got.vertex_index = vertex_index;
            got.is_new       = is_new;
            got.table_full   = table_full;
            got.pos_x        = out_pos_x;
            got.pos_y        = out_pos_y;
            got.pos_z        = out_pos_z;
            got.nrm_x        = out_nrm_x;
            got.nrm_y        = out_nrm_y;
            got.nrm_z        = out_nrm_z;
            got.unique_count = unique_count;
            weld_sb.check_result(got);
        end
    end

    // hold start with the fields until the block takes the transaction;
    // busy is read before the edge updates land, so it is the pre-edge value
    task send_cmd(logic [1:0] c, logic [15:0] px, logic [15:0] py, logic [15:0] pz,
                  logic [15:0] nx, logic [15:0] ny, logic [15:0] nz, logic [7:0] ri);
        start      <= 1'b1;
        cmd        <= c;
        pos_x      <= px;
        pos_y      <= py;
        pos_z      <= pz;
        nrm_x      <= nx;
        nrm_y      <= ny;
        nrm_z      <= nz;
        read_index <= ri;
        do
            @(posedge clk);
        while (busy);
        weld_sb.note_accepted(c, px, py, pz, nx, ny, nz, ri);
    endtask

    // random sender gaps, mostly short, now and then spanning a whole search
    task maybe_idle();
        if (!no_gaps && $urandom_range(0, 99) < 13) begin
            start <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 600)) @(posedge clk);
            else
                repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // drop start and wait until the block owes nothing and is idle
    task drain();
        start <= 1'b0;
        @(posedge clk);
        while (weld_sb.owed_results.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // setup then access cycle; pready is always high
    task reg_write(logic [vwd_pkg::CFG_AW-1:0] addr, logic [vwd_pkg::CFG_DW-1:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MODE)
            weld_sb.tol_mode = data[0];
        else
            weld_sb.dist_sq = data[vwd_pkg::DIST_W-1:0];
        @(posedge clk);
    endtask

    task set_weld(bit mode, logic [vwd_pkg::DIST_W-1:0] dist_val);
        drain();
        reg_write(ADDR_MODE, {63'd0, mode});
        reg_write(ADDR_DIST, {28'd0, dist_val});
    endtask

    // one random phase: mostly inserts from the pool with small jitter,
    // some full-range noise, reads, no-ops and the odd clear
    task random_phase(int n_items);
        int i, k, r, jit;
        logic [15:0] px, py, pz;
        for (k = 0; k < 12; k++) begin
            pool_x[k] = rnd16();
            pool_y[k] = rnd16();
            pool_z[k] = rnd16();
        end
        for (i = 0; i < n_items; i++) begin
            no_gaps = (i >= n_items / 3) && (i < n_items / 2);
            r = $urandom_range(0, 99);
            if (r < 70) begin
                if ($urandom_range(0, 9) < 7) begin
                    k   = $urandom_range(0, 11);
                    jit = weld_sb.tol_mode ? 20 : 0;
                    if ($urandom_range(0, 1) == 0)
                        jit = 0;
                    px = pool_x[k] + 16'($urandom_range(0, 2 * jit)) - 16'(jit);
                    py = pool_y[k] + 16'($urandom_range(0, 2 * jit)) - 16'(jit);
                    pz = pool_z[k] + 16'($urandom_range(0, 2 * jit)) - 16'(jit);
                end else begin
                    px = rnd16();
                    py = rnd16();
                    pz = rnd16();
                end
                send_cmd(vwd_pkg::CMD_INSERT, px, py, pz, rnd16(), rnd16(), rnd16(),
                         rnd8());
            end else if (r < 88) begin
                send_cmd(vwd_pkg::CMD_READ, rnd16(), rnd16(), rnd16(), rnd16(), rnd16(),
                         rnd16(), ($urandom_range(0, 4) < 3) ?
                         8'($urandom_range(0, weld_sb.entries + 2)) : rnd8());
            end else if (r < 95) begin
                send_cmd(CMD_NOP, rnd16(), rnd16(), rnd16(), rnd16(), rnd16(),
                         rnd16(), rnd8());
            end else begin
                send_cmd(vwd_pkg::CMD_CLEAR, rnd16(), rnd16(), rnd16(), rnd16(), rnd16(),
                         rnd16(), rnd8());
            end
            maybe_idle();
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        int i;
        no_gaps = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: field extremes, every command, hit, near miss, clear
        send_cmd(vwd_pkg::CMD_INSERT, 16'h7fff, 16'h8000, 16'h0000, 16'h7fff, 16'h8000,
                 16'h0001, 8'hff);
        send_cmd(vwd_pkg::CMD_INSERT, 16'h7fff, 16'h8000, 16'h0000, 16'h7fff, 16'h8000,
                 16'hffff, 8'h00);
        send_cmd(vwd_pkg::CMD_INSERT, 16'h7fff, 16'h8000, 16'h0001, 16'h8000, 16'h7fff,
                 16'h0000, 8'h00);
        send_cmd(vwd_pkg::CMD_INSERT, 16'h8000, 16'h7fff, 16'hffff, 16'h0000, 16'h0000,
                 16'h0000, 8'h00);
        send_cmd(vwd_pkg::CMD_READ, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 8'd0);
        send_cmd(vwd_pkg::CMD_READ, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 8'd2);
        send_cmd(vwd_pkg::CMD_READ, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 8'd3);
        send_cmd(vwd_pkg::CMD_READ, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 8'd255);
        send_cmd(CMD_NOP, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'hff);
        send_cmd(vwd_pkg::CMD_CLEAR, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 8'd0);
        send_cmd(vwd_pkg::CMD_READ, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 8'd0);
        send_cmd(vwd_pkg::CMD_INSERT, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000,
                 16'h0000, 8'd0);
        send_cmd(vwd_pkg::CMD_READ, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 8'd0);

        // tolerance mode at the reset distance: points just inside it
        set_weld(1'b1, vwd_pkg::DIST_RESET);
        send_cmd(vwd_pkg::CMD_INSERT, 16'd11, 16'd11, 16'd10, 16'h0010, 16'h0, 16'h0, 8'd0);
        send_cmd(vwd_pkg::CMD_INSERT, 16'd11, 16'd11, 16'd11, 16'h0010, 16'h0, 16'h0, 8'd0);
        send_cmd(vwd_pkg::CMD_INSERT, 16'hfff0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 8'd0);
        send_cmd(vwd_pkg::CMD_READ, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 8'd0);
        // zero distance never matches, the largest matches anything
        set_weld(1'b1, '0);
        send_cmd(vwd_pkg::CMD_INSERT, 16'd0, 16'd0, 16'd0, 16'h0, 16'h0, 16'h0, 8'd0);
        set_weld(1'b1, DIST_MAX);
        send_cmd(vwd_pkg::CMD_INSERT, 16'h8000, 16'h8000, 16'h8000, 16'h0, 16'h0, 16'h0, 8'd0);
        send_cmd(vwd_pkg::CMD_INSERT, 16'h7fff, 16'h7fff, 16'h7fff, 16'h0, 16'h0, 16'h0, 8'd0);

        // random phases across several register settings
        set_weld(1'b0, vwd_pkg::DIST_RESET);
        random_phase(8);
        set_weld(1'b1, vwd_pkg::DIST_RESET);
        random_phase(6);
        set_weld(1'b1, '0);
        random_phase(3);
        set_weld(1'b1, DIST_MAX);
        random_phase(3);
        set_weld(1'b1, 36'($urandom_range(0, 4000)));
        random_phase(6);
        set_weld(1'b1, vwd_pkg::DIST_W'({$urandom, $urandom}));
        random_phase(4);

        // saturate the normal sums of one entry, positive on x, negative on y
        set_weld(1'b0, vwd_pkg::DIST_RESET);
        send_cmd(vwd_pkg::CMD_CLEAR, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 8'd0);
        for (i = 0; i < 258; i++) begin
            send_cmd(vwd_pkg::CMD_INSERT, 16'h1234, 16'h5678, 16'h9abc, 16'h7fff, 16'h8000,
                     rnd16(), 8'd0);
            maybe_idle();
        end
        send_cmd(vwd_pkg::CMD_READ, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 8'd0);

        // sender holds off until all results are back
        drain();

        // fill the table, then miss on a full table and hit its last entry
        send_cmd(vwd_pkg::CMD_CLEAR, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 8'd0);
        for (i = 0; i < 256; i++) begin
            no_gaps = (i >= 64) && (i < 192);
            send_cmd(vwd_pkg::CMD_INSERT, 16'(i), 16'(i * 3), 16'h8000 + 16'(i), rnd16(),
                     rnd16(), rnd16(), 8'd0);
            maybe_idle();
        end
        no_gaps = 1'b0;
        send_cmd(vwd_pkg::CMD_INSERT, 16'h7fff, 16'h7fff, 16'h7fff, 16'h1, 16'h1, 16'h1, 8'd0);
        send_cmd(vwd_pkg::CMD_INSERT, 16'd255, 16'd765, 16'h80ff, 16'h1, 16'h1, 16'h1, 8'd0);
        send_cmd(vwd_pkg::CMD_READ, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 8'd255);
        send_cmd(CMD_NOP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 8'd0);

        drain();
        repeat (20) @(posedge clk);

        $display("tb: %0d results checked: %0d new, %0d hits, %0d full misses, %0d reads",
                 weld_sb.n_checked, weld_sb.n_new, weld_sb.n_hits, weld_sb.n_full,
                 weld_sb.n_reads);
        $display("tb: exact and tolerance welding, distances zero to max, saturation, fill");
        if (weld_sb.mismatches == 0 && weld_sb.owed_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial
    begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end
endmodule
